FILE: rtl/core/bis_pkg.sv
`default_nettype none

package bis_pkg;

  // item opcodes
  localparam logic [1:0] OP_LOAD_DATA  = 2'd0;
  localparam logic [1:0] OP_LOAD_INDEX = 2'd1;
  localparam logic [1:0] OP_SEARCH     = 2'd2;

  // configuration register indexes
  localparam logic [7:0] CFG_BLOCK_COUNT = 8'd0;
  localparam logic [7:0] CFG_SEARCH_MODE = 8'd1;

  typedef struct packed {
    logic [1:0]         op;
    logic [7:0]         slot;
    logic signed [31:0] value;
    logic [7:0]         block_first;
    logic [7:0]         block_last;
  } item_t;

  typedef struct packed {
    logic       found;
    logic [7:0] position;
  } result_t;

  typedef struct packed {
    logic signed [31:0] key;
    logic [7:0]         first;
    logic [7:0]         last;
  } idx_entry_t;

  // comparator flags, key against operand
  typedef struct packed {
    logic lt;
    logic eq;
    logic gt;
  } cmp_t;

endpackage

`default_nettype wire

FILE: rtl/core/bis_cmp.sv
`default_nettype none

module bis_cmp (
  input  wire logic signed [31:0] key_i,
  input  wire logic signed [31:0] opnd_i,
  output bis_pkg::cmp_t           cmp_o
);
  import bis_pkg::*;

  // signed two's-complement compare, shared by index and data walks
  always_comb begin
    cmp_o.lt = key_i < opnd_i;
    cmp_o.eq = key_i == opnd_i;
    cmp_o.gt = key_i > opnd_i;
  end

endmodule

`default_nettype wire

FILE: rtl/core/block_index_search.sv
`default_nettype none

// Indexed block search. Loads take effect at the accepting edge; busy stays low, no result.
// Search: the sequencer visits k index entries (linear: up to block_count, binary: about
//   log2(block_count)+1), latches the chosen block's bounds, then compares s data slots.
// Key above all blocks: no block read; empty block: no slot compared; empty table: no entry visited.
// One search at a time on one shared comparator; busy drops with the strobe. No stall.
// Reset: sequencer to idle, strobe and config registers to 0; data store and index are not cleared.
module block_index_search #(
  parameter int DATA_DEPTH  = 256,
  parameter int INDEX_DEPTH = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // command channel
  input  wire logic              start,
  output logic                   busy,
  input  wire bis_pkg::item_t    item_i,
  // result strobe
  output logic                   done_o,
  output bis_pkg::result_t       result_o,
  // configuration write channel
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [7:0]        cfg_index_i,
  input  wire logic [31:0]       cfg_data_i
);
  import bis_pkg::*;

  localparam int AW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
  localparam int IW = (INDEX_DEPTH > 1) ? $clog2(INDEX_DEPTH) : 1;

  // one-hot sequencer
  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_IDX_RD  = 7'b0000010,  // read index entry (i for linear, mid for binary)
    S_IDX_CMP = 7'b0000100,  // compare search key with entry key
    S_BLK_RD  = 7'b0001000,  // read chosen entry's bounds
    S_BLK_LD  = 7'b0010000,  // latch bounds, issue first data read
    S_DAT_CMP = 7'b0100000,  // compare one data slot per cycle
    S_UNUSED  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // config
  logic [4:0] block_count_q;
  logic       search_mode_q;

  // search context
  logic signed [31:0] key_q,   key_d;
  logic               mode_q,  mode_d;
  logic [8:0]         n_q,     n_d;
  logic [8:0]         i_q,     i_d;
  logic [8:0]         low_q,   low_d;
  logic signed [9:0]  high_q,  high_d;
  logic [IW-1:0]      b_q,     b_d;
  logic [7:0]         cur_q,   cur_d;
  logic [7:0]         last_q,  last_d;

  logic    out_valid_q, out_valid_d;
  result_t res_q,       res_d;

  // memories
  logic signed [31:0] data_mem [DATA_DEPTH];
  idx_entry_t         idx_mem  [INDEX_DEPTH];
  logic signed [31:0] data_rd_q;
  idx_entry_t         idx_rd_q;

  logic               data_we, idx_we;
  logic [AW-1:0]      data_waddr, data_raddr;
  logic [IW-1:0]      idx_waddr,  idx_raddr;

  logic               accept;
  logic [9:0]         mid_sum;
  logic [8:0]         mid;
  logic [8:0]         n_clamp;
  logic signed [31:0] cmp_opnd;
  cmp_t               cmp;

  logic [8:0]         bin_low;
  logic signed [9:0]  bin_high;

  assign accept      = start && !busy;
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign done_o      = out_valid_q;
  assign result_o    = res_q;

  // binary midpoint; low and high are both non-negative while the loop runs
  assign mid_sum = {1'b0, low_q} + high_q;
  assign mid     = mid_sum[9:1];

  assign n_clamp = (32'(block_count_q) > INDEX_DEPTH) ? 9'(INDEX_DEPTH) : 9'(block_count_q);

  // shared comparator: index key during the index walk, data slot during the block scan
  assign cmp_opnd = (state_q == S_DAT_CMP) ? data_rd_q : idx_rd_q.key;

  bis_cmp u_cmp (
    .key_i  (key_q),
    .opnd_i (cmp_opnd),
    .cmp_o  (cmp)
  );

  // load writes
  assign data_we    = accept && (item_i.op == OP_LOAD_DATA) &&
                      (32'(item_i.slot) < DATA_DEPTH);
  assign idx_we     = accept && (item_i.op == OP_LOAD_INDEX) &&
                      (32'(item_i.slot) < INDEX_DEPTH);
  assign data_waddr = AW'(item_i.slot);
  assign idx_waddr  = IW'(item_i.slot);

  // read address select
  always_comb begin
    if (state_q == S_BLK_RD) begin
      idx_raddr = b_q;
    end else if (mode_q) begin
      idx_raddr = IW'(mid);
    end else begin
      idx_raddr = IW'(i_q);
    end
    if (state_q == S_BLK_LD) begin
      data_raddr = AW'(idx_rd_q.first);
    end else begin
      data_raddr = AW'(cur_q + 8'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (data_we) begin
      data_mem[data_waddr] <= item_i.value;
    end
    data_rd_q <= data_mem[data_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (idx_we) begin
      idx_mem[idx_waddr] <= '{key: item_i.value, first: item_i.block_first,
                              last: item_i.block_last};
    end
    idx_rd_q <= idx_mem[idx_raddr];
  end

  // binary step outcome
  always_comb begin
    bin_low  = low_q;
    bin_high = high_q;
    if (cmp.lt) begin
      bin_high = $signed({1'b0, mid}) - 10'sd1;
    end else if (cmp.gt) begin
      bin_low = mid + 9'd1;
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    key_d       = key_q;
    mode_d      = mode_q;
    n_d         = n_q;
    i_d         = i_q;
    low_d       = low_q;
    high_d      = high_q;
    b_d         = b_q;
    cur_d       = cur_q;
    last_d      = last_q;
    out_valid_d = 1'b0;
    res_d       = res_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept && (item_i.op == OP_SEARCH)) begin
          key_d  = item_i.value;
          mode_d = search_mode_q;
          n_d    = n_clamp;
          i_d    = '0;
          low_d  = '0;
          high_d = $signed({1'b0, n_clamp}) - 10'sd1;
          if (n_clamp == '0) begin
            // empty table: not found at once
            out_valid_d = 1'b1;
            res_d       = '0;
          end else begin
            state_d = S_IDX_RD;
          end
        end
      end

      S_IDX_RD: begin
        state_d = S_IDX_CMP;
      end

      S_IDX_CMP: begin
        if (!mode_q) begin
          if (cmp.gt) begin
            if (i_q + 9'd1 >= n_q) begin
              // key above every block
              out_valid_d = 1'b1;
              res_d       = '0;
              state_d     = S_IDLE;
            end else begin
              i_d     = i_q + 9'd1;
              state_d = S_IDX_RD;
            end
          end else begin
            b_d     = IW'(i_q);
            state_d = S_BLK_RD;
          end
        end else begin
          low_d  = bin_low;
          high_d = bin_high;
          if (cmp.eq) begin
            b_d     = IW'(mid);
            state_d = S_BLK_RD;
          end else if ($signed({1'b0, bin_low}) <= bin_high) begin
            state_d = S_IDX_RD;
          end else if (bin_low >= n_q) begin
            out_valid_d = 1'b1;
            res_d       = '0;
            state_d     = S_IDLE;
          end else begin
            b_d     = IW'(bin_low);
            state_d = S_BLK_RD;
          end
        end
      end

      S_BLK_RD: begin
        state_d = S_BLK_LD;
      end

      S_BLK_LD: begin
        if (idx_rd_q.first > idx_rd_q.last) begin
          // empty block
          out_valid_d = 1'b1;
          res_d       = '0;
          state_d     = S_IDLE;
        end else begin
          cur_d   = idx_rd_q.first;
          last_d  = idx_rd_q.last;
          state_d = S_DAT_CMP;
        end
      end

      S_DAT_CMP: begin
        if (cmp.eq && (32'(cur_q) < DATA_DEPTH)) begin
          out_valid_d    = 1'b1;
          res_d.found    = 1'b1;
          res_d.position = cur_q;
          state_d        = S_IDLE;
        end else if (cur_q == last_q) begin
          out_valid_d = 1'b1;
          res_d       = '0;
          state_d     = S_IDLE;
        end else begin
          cur_d = cur_q + 8'd1;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      out_valid_q   <= 1'b0;
      block_count_q <= '0;
      search_mode_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_BLOCK_COUNT: block_count_q <= cfg_data_i[4:0];
          CFG_SEARCH_MODE: search_mode_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // payload and search context, no reset needed
  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    mode_q <= mode_d;
    n_q    <= n_d;
    i_q    <= i_d;
    low_q  <= low_d;
    high_q <= high_d;
    b_q    <= b_d;
    cur_q  <= cur_d;
    last_q <= last_d;
    res_q  <= res_d;
  end

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bis_pkg::*;

  localparam int DATA_SLOTS   = 256;
  localparam int INDEX_SLOTS  = 16;
  // worst search: 16 index visits plus a 256-slot block
  localparam int SEARCH_WORST = 300;
  localparam int RANDOM_ITEMS = 1000;
  localparam int PHASE_ITEMS  = 100;
  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int KEY_MAX      = 32'sh7FFF_FFFF;
  localparam int KEY_MIN      = 32'sh8000_0000;
  // op code the block has no use for; an item carrying it is dropped
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT
  // ---------------------------------------------------------------------------
  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        start       = 1'b0;
  logic        busy;
  item_t       cmd_item    = '0;
  logic        done_o;
  result_t     result_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i  = '0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  block_index_search #(
    .DATA_DEPTH (DATA_SLOTS),
    .INDEX_DEPTH(INDEX_SLOTS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (cmd_item),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the block: data store, index table, both registers.
  // Updated at the edge that accepts an item or a register write.
  // ---------------------------------------------------------------------------
  int         shadow_data  [DATA_SLOTS];
  int         shadow_key   [INDEX_SLOTS];
  int         shadow_first [INDEX_SLOTS];
  int         shadow_last  [INDEX_SLOTS];
  logic [4:0] shadow_count  = '0;
  logic       shadow_binary = 1'b0;

  result_t    pending_lookups [$];  // search answers not yet seen on the strobe
  int         items_done     = 0;   // items that loaded or searched something
  int         mismatch_count = 0;
  int         cycle_count    = 0;
  bit         steady_phase   = 1'b0;  // no idle gaps on the command side

  // Search answer for one key against the shadow state.
  function automatic result_t lookup_key(int key);
    int      n, blk, lo, hi, mid, j;
    result_t res;
    res = '0;
    n = (shadow_count > INDEX_SLOTS) ? INDEX_SLOTS : int'(shadow_count);
    if (shadow_binary) begin
      // binary index search: low bound is the pick, also with unsorted keys
      lo = 0;
      hi = n - 1;
      while (lo <= hi) begin
        mid = (lo + hi) / 2;
        if (key < shadow_key[mid]) hi = mid - 1;
        else if (key > shadow_key[mid]) lo = mid + 1;
        else begin
          lo = mid;
          break;
        end
        if (hi < 0) break;
      end
      blk = (n == 0 || lo >= n) ? -1 : lo;
    end else begin
      // linear scan: first entry whose key is not below the search key
      blk = 0;
      while (blk < n && key > shadow_key[blk]) blk++;
      if (blk >= n) blk = -1;
    end
    // first > last leaves the block empty; the loop simply does not run
    if (blk >= 0) begin
      for (j = shadow_first[blk]; j <= shadow_last[blk]; j++) begin
        if (j < DATA_SLOTS && shadow_data[j] == key) begin
          res.found    = 1'b1;
          res.position = 8'(j);
          break;
        end
      end
    end
    return res;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] ERROR %s", $time, what);
  endtask

  // Command-side idle length: mostly back to back, some short gaps, a few long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one item, hold it until start && !busy at an edge, then update
  // the shadow state. typed/want let a directed row supply its own answer.
  task automatic send_item(input item_t it, input bit typed = 1'b0,
                           input result_t want = '0);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start    <= 1'b1;
    cmd_item <= it;
    do @(posedge clk_i); while (busy);
    case (it.op)
      OP_LOAD_DATA: begin
        shadow_data[it.slot] = it.value;
        items_done++;
      end
      OP_LOAD_INDEX: begin
        // entries past the table are dropped by the block
        if (it.slot < INDEX_SLOTS) begin
          shadow_key[it.slot]   = it.value;
          shadow_first[it.slot] = it.block_first;
          shadow_last[it.slot]  = it.block_last;
          items_done++;
        end
      end
      OP_SEARCH: begin
        pending_lookups.insert(pending_lookups.size(),
                               typed ? want : lookup_key(it.value));
        items_done++;
      end
      default: ;
    endcase
  endtask

  // Wait for the block to go quiet. Loads land at the accepting edge, so the
  // wait only has to outlast the last search answer.
  task automatic settle();
    start <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [31:0] data);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_BLOCK_COUNT) shadow_count = data[4:0];
    else if (idx == CFG_SEARCH_MODE) shadow_binary = data[0];
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: every strobe must match the oldest pending answer.
  // ---------------------------------------------------------------------------
  result_t strobe_want;

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_lookups.size() == 0) begin
        flag_mismatch($sformatf("unexpected result strobe: found=%0b position=%0d",
                                result_o.found, result_o.position));
      end else begin
        strobe_want = pending_lookups.pop_front();
        if (result_o.found !== strobe_want.found)
          flag_mismatch($sformatf("field found: got %0b want %0b",
                                  result_o.found, strobe_want.found));
        if (result_o.position !== strobe_want.position)
          flag_mismatch($sformatf("field position: got %0d want %0d",
                                  result_o.position, strobe_want.position));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("[%0t] ERROR run did not finish in %0d cycles", $time, LIMIT_CYCLES);
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed rows. ROW_CFG uses slot as register index and value as data.
  // ROW_FILL writes every data slot and index entry with a sorted layout:
  //   slot s holds 4*s - 512, entry b covers slots 16b..16b+15 with key
  //   64*b - 452, so the typed answers below can be read off directly.
  // ---------------------------------------------------------------------------
  typedef enum logic [1:0] { ROW_ITEM, ROW_CFG, ROW_FILL } row_kind_e;

  typedef struct {
    row_kind_e  kind;
    logic [1:0] op;
    logic [7:0] slot;
    int         value;
    logic [7:0] first;
    logic [7:0] last;
    bit         typed;
    bit         found;
    logic [7:0] pos;
  } dir_row_t;

  localparam int DIR_ROWS = 27;

  dir_row_t dir_rows [DIR_ROWS] = '{
    // right after reset: no entries in use, linear then binary
    '{ROW_ITEM, OP_SEARCH,     8'd0,            0,        8'd0,   8'd0,   1'b1, 1'b0, 8'd0},
    '{ROW_ITEM, OP_UNUSED,     8'hA5,           32'sh5A5A_C3C3, 8'hFF, 8'h0F, 1'b0, 1'b0, 8'd0},
    '{ROW_CFG,  OP_UNUSED,     CFG_SEARCH_MODE, 1,        8'd0,   8'd0,   1'b0, 1'b0, 8'd0},
    '{ROW_ITEM, OP_SEARCH,     8'd0,            5,        8'd0,   8'd0,   1'b1, 1'b0, 8'd0},
    '{ROW_FILL, OP_UNUSED,     8'd0,            0,        8'd0,   8'd0,   1'b0, 1'b0, 8'd0},
    '{ROW_CFG,  OP_UNUSED,     CFG_BLOCK_COUNT, 16,       8'd0,   8'd0,   1'b0, 1'b0, 8'd0},
    // binary: first and last slot, just above the top key, both key extremes
    '{ROW_ITEM, OP_SEARCH,     8'd0,            -512,     8'd0,   8'd0,   1'b1, 1'b1, 8'd0},
    '{ROW_ITEM, OP_SEARCH,     8'd0,            508,      8'd0,   8'd0,   1'b1, 1'b1, 8'd255},
    '{ROW_ITEM, OP_SEARCH,     8'd0,            509,      8'd0,   8'd0,   1'b1, 1'b0, 8'd0},
    '{ROW_ITEM, OP_SEARCH,     8'd0,            KEY_MAX,  8'd0,   8'd0,   1'b1, 1'b0, 8'd0},
    '{ROW_ITEM, OP_SEARCH,     8'd0,            KEY_MIN,  8'd0,   8'd0,   1'b1, 1'b0, 8'd0},
    '{ROW_ITEM, OP_SEARCH,     8'd0,            2,        8'd0,   8'd0,   1'b0, 1'b0, 8'd0},
    '{ROW_CFG,  OP_UNUSED,     CFG_SEARCH_MODE, 0,        8'd0,   8'd0,   1'b0, 1'b0, 8'd0},
    '{ROW_ITEM, OP_SEARCH,     8'd0,            508,      8'd0,   8'd0,   1'b1, 1'b1, 8'd255},
    '{ROW_ITEM, OP_SEARCH,     8'd0,            KEY_MAX,  8'd0,   8'd0,   1'b1, 1'b0, 8'd0},
    // count past the table depth is clamped to 16
    '{ROW_CFG,  OP_UNUSED,     CFG_BLOCK_COUNT, 31,       8'd0,   8'd0,   1'b0, 1'b0, 8'd0},
    '{ROW_ITEM, OP_SEARCH,     8'd0,            -512,     8'd0,   8'd0,   1'b1, 1'b1, 8'd0},
    // index entry past the table: dropped
    '{ROW_ITEM, OP_LOAD_INDEX, 8'd255,          KEY_MIN,  8'd255, 8'd0,   1'b0, 1'b0, 8'd0},
    '{ROW_ITEM, OP_LOAD_DATA,  8'd255,          KEY_MIN,  8'd0,   8'd0,   1'b0, 1'b0, 8'd0},
    '{ROW_ITEM, OP_SEARCH,     8'd0,            KEY_MIN,  8'd0,   8'd0,   1'b0, 1'b0, 8'd0},
    // entry 3 turned into an empty block (first after last)
    '{ROW_ITEM, OP_LOAD_INDEX, 8'd3,            -260,     8'd200, 8'd100, 1'b0, 1'b0, 8'd0},
    '{ROW_ITEM, OP_SEARCH,     8'd0,            -264,     8'd0,   8'd0,   1'b0, 1'b0, 8'd0},
    // last entry spans the whole store, match deep inside it
    '{ROW_ITEM, OP_LOAD_DATA,  8'd200,          KEY_MAX,  8'd0,   8'd0,   1'b0, 1'b0, 8'd0},
    '{ROW_ITEM, OP_LOAD_INDEX, 8'd15,           KEY_MAX,  8'd0,   8'd255, 1'b0, 1'b0, 8'd0},
    '{ROW_ITEM, OP_SEARCH,     8'd0,            KEY_MAX,  8'd0,   8'd0,   1'b0, 1'b0, 8'd0},
    '{ROW_CFG,  OP_UNUSED,     CFG_SEARCH_MODE, 1,        8'd0,   8'd0,   1'b0, 1'b0, 8'd0},
    '{ROW_ITEM, OP_SEARCH,     8'd0,            KEY_MAX,  8'd0,   8'd0,   1'b0, 1'b0, 8'd0}
  };

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int          s, b, j, pick, base, len, val, phase;
    logic [31:0] reg_val;
    item_t       cmd;
    result_t     want;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    foreach (dir_rows[r]) begin
      case (dir_rows[r].kind)
        ROW_CFG: write_reg(dir_rows[r].slot, dir_rows[r].value);
        ROW_FILL: begin
          for (s = 0; s < DATA_SLOTS; s++)
            send_item('{OP_LOAD_DATA, 8'(s), 4 * s - 512, 8'd0, 8'd0});
          for (b = 0; b < INDEX_SLOTS; b++)
            send_item('{OP_LOAD_INDEX, 8'(b), 64 * b - 452, 8'(16 * b), 8'(16 * b + 15)});
        end
        default: begin
          cmd          = '{dir_rows[r].op, dir_rows[r].slot, dir_rows[r].value,
                           dir_rows[r].first, dir_rows[r].last};
          want.found    = dir_rows[r].found;
          want.position = dir_rows[r].pos;
          send_item(cmd, dir_rows[r].typed, want);
        end
      endcase
    end

    // random part, in phases with fresh register settings
    items_done = 0;
    phase      = 0;
    while (items_done < RANDOM_ITEMS) begin
      case ($urandom_range(0, 7))
        0:       reg_val = 0;
        1:       reg_val = INDEX_SLOTS;
        2:       reg_val = 31;
        3:       reg_val = $urandom_range(17, 30);
        default: reg_val = $urandom_range(1, 16);
      endcase
      // upper data bits are don't-care for both registers
      write_reg(CFG_BLOCK_COUNT, ($urandom() & ~32'h1F) | reg_val);
      write_reg(CFG_SEARCH_MODE, ($urandom() & ~32'h1) | $urandom_range(0, 1));
      steady_phase = ($urandom_range(0, 3) == 0);

      // Every third phase lays out a fresh sorted store: short blocks back to
      // back, an occasional long one, an occasional empty one, duplicates
      // allowed so the first-match rule gets exercised.
      if (phase % 3 == 0) begin
        base = $urandom_range(0, 24);
        val  = int'($urandom_range(0, 200000)) - 100000;
        for (b = 0; b < INDEX_SLOTS; b++) begin
          len = ($urandom_range(0, 15) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 8);
          if ($urandom_range(0, 15) == 0) len = 0;
          if (base + len > DATA_SLOTS) base = 0;
          for (s = base; s < base + len; s++) begin
            val += $urandom_range(0, 3);
            send_item('{OP_LOAD_DATA, 8'(s), val, 8'($urandom()), 8'($urandom())});
          end
          if (len == 0)
            send_item('{OP_LOAD_INDEX, 8'(b), val, 8'(base + 1), 8'(base)});
          else
            send_item('{OP_LOAD_INDEX, 8'(b), val, 8'(base), 8'(base + len - 1)});
          base += len;
        end
      end

      repeat (PHASE_ITEMS) begin
        // unused fields carry random bits too
        cmd.op          = OP_SEARCH;
        cmd.slot        = 8'($urandom());
        cmd.value       = $urandom();
        cmd.block_first = 8'($urandom());
        cmd.block_last  = 8'($urandom());
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          // key taken from the store, or one off it
          j = $urandom_range(0, DATA_SLOTS - 1);
          case ($urandom_range(0, 4))
            3:       cmd.value = shadow_data[j] + 1;
            4:       cmd.value = shadow_data[j] - 1;
            default: cmd.value = shadow_data[j];
          endcase
        end else if (pick < 62) begin
          cmd.value = shadow_key[$urandom_range(0, INDEX_SLOTS - 1)];
        end else if (pick >= 70 && pick < 85) begin
          cmd.op = OP_LOAD_DATA;
          if ($urandom_range(0, 3) != 0)
            cmd.value = shadow_data[cmd.slot] + int'($urandom_range(0, 4)) - 2;
        end else if (pick >= 85 && pick < 95) begin
          cmd.op = OP_LOAD_INDEX;
          // mostly a short plausible block; otherwise raw noise, slot may be
          // past the table
          if ($urandom_range(0, 3) != 0) begin
            cmd.slot        = 8'($urandom_range(0, INDEX_SLOTS - 1));
            cmd.block_first = 8'($urandom_range(0, 250));
            cmd.block_last  = cmd.block_first + 8'($urandom_range(0, 5));
            cmd.value       = shadow_data[cmd.block_last];
          end
        end else if (pick >= 95) begin
          cmd.op = OP_UNUSED;
        end
        send_item(cmd);
      end
      phase++;
    end

    // drain, then give a late or extra strobe time to show up
    settle();
    repeat (SEARCH_WORST) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
